@@ sv/vld_pkg.sv @@
// shared types and codes for the varint length and id deframer
`default_nettype none
package vld_pkg;

   // result kind carried on the rsp tuser field
   typedef enum logic [2:0] {
      ST_HDR      = 3'd0,
      ST_PAY      = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_LEN_LONG = 3'd3,
      ST_ID_LONG  = 3'd4,
      ST_SHORT    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_LEN = 2'd0,
      PH_ID  = 2'd1,
      PH_PAY = 2'd2
   } phase_type;

   // one classified stream byte as queued between front and back
   typedef struct packed {
      logic [7:0] raw;
      logic       more;
   } item_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage
`default_nettype wire

@@ sv/vld_front.sv @@
// front end: byte intake, continuation classification and a two-entry queue
`default_nettype none
module vld_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   output vld_pkg::queue_out_type     q_out,
   input  wire logic                  q_pop
);
   import vld_pkg::*;

   item_type    q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;
   item_type    new_item;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (count_ff != 2'd0);

   always_comb begin
      new_item.raw  = req_tdata;
      new_item.more = req_tdata[7];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      q_out.valid = (count_ff != 2'd0);
      q_out.item  = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

@@ sv/vld_back.sv @@
// back end: varint decoding, frame state and the result register
`default_nettype none
module vld_back #(
   parameter int MAX_VARINT_BYTES = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vld_pkg::queue_out_type q_out,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [71:0]                rsp_tdata,
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tlast
);
   import vld_pkg::*;

   localparam logic [2:0] MaxBytes = 3'(MAX_VARINT_BYTES);

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] flen_ff, flen_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] remain_ff, remain_in;

   logic        out_valid_ff, out_valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [31:0] pid_ff, pid_in;
   logic [31:0] plen_ff, plen_in;
   logic        last_ff, last_in;

   logic [5:0]  shamt;
   logic [63:0] part;
   logic [31:0] acc_new;
   logic [2:0]  cnt_new;
   logic [31:0] cnt_wide;
   logic [31:0] remain_dec;
   logic        overlong;
   logic        pop;

   assign pop   = q_out.valid && (!out_valid_ff || rsp_tready);
   assign q_pop = pop;

   always_comb begin
      // shift by 7 * count, bits beyond 31 fall away
      shamt    = {cnt_ff, 3'b000} - {3'b000, cnt_ff};
      part     = 64'(q_out.item.raw[6:0]) << shamt;
      acc_new  = acc_ff | part[31:0];
      cnt_new  = cnt_ff + 3'd1;
      cnt_wide = 32'(cnt_new);
      overlong = q_out.item.more && (cnt_new >= MaxBytes);
      remain_dec = remain_ff - 32'd1;

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      flen_in   = flen_ff;
      id_in     = id_ff;
      remain_in = remain_ff;
      status_in = ST_HDR;
      pbyte_in  = '0;
      pid_in    = '0;
      plen_in   = '0;
      last_in   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;

      if (pop) begin
         out_valid_in = 1'b1;
         unique case (phase_ff)
            PH_PAY: begin
               status_in = ST_PAY;
               pbyte_in  = q_out.item.raw;
               pid_in    = id_ff;
               plen_in   = flen_ff;
               remain_in = remain_dec;
               if (remain_dec == 32'd0) begin
                  last_in  = 1'b1;
                  phase_in = PH_LEN;
                  acc_in   = '0;
                  cnt_in   = '0;
               end
            end
            PH_ID: begin
               if (overlong) begin
                  status_in = ST_ID_LONG;
                  phase_in  = PH_LEN;
                  acc_in    = '0;
                  cnt_in    = '0;
               end else if (!q_out.item.more) begin
                  id_in  = acc_new;
                  acc_in = '0;
                  cnt_in = '0;
                  if (flen_ff < cnt_wide) begin
                     status_in = ST_SHORT;
                     phase_in  = PH_LEN;
                  end else begin
                     flen_in   = flen_ff - cnt_wide;
                     remain_in = flen_ff - cnt_wide;
                     if (flen_ff == cnt_wide) begin
                        status_in = ST_EMPTY;
                        pid_in    = acc_new;
                        last_in   = 1'b1;
                        phase_in  = PH_LEN;
                     end else begin
                        phase_in = PH_PAY;
                     end
                  end
               end else begin
                  acc_in = acc_new;
                  cnt_in = cnt_new;
               end
            end
            default: begin
               // length varint, also taken for the unused phase code
               if (overlong) begin
                  status_in = ST_LEN_LONG;
                  phase_in  = PH_LEN;
                  acc_in    = '0;
                  cnt_in    = '0;
               end else if (!q_out.item.more) begin
                  flen_in  = acc_new;
                  phase_in = PH_ID;
                  acc_in   = '0;
                  cnt_in   = '0;
               end else begin
                  acc_in = acc_new;
                  cnt_in = cnt_new;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEN;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         flen_ff      <= '0;
         id_ff        <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         flen_ff      <= flen_in;
         id_ff        <= id_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         pbyte_ff  <= pbyte_in;
         pid_ff    <= pid_in;
         plen_ff   <= plen_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {plen_ff, pid_ff, pbyte_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

@@ sv/varint_length_id_deframer_top.sv @@
// top level of the varint length and id deframer
//
// req channel: one raw stream byte per beat on req_tdata.
// rsp channel: exactly one result beat per request beat, in order.
//   rsp_tuser is the status (header byte, payload byte, empty packet,
//   length too long, id too long, length below id size); rsp_tdata
//   carries the payload byte, packet id and payload length; rsp_tlast
//   marks the final payload byte or an empty packet.
// a request beat passes through the queue entry and then the result register.
// throughput: one byte per cycle while rsp_tready stays high, with a decode step
//   in the back end of one shift, OR and 32-bit compare per byte.
// a two-entry queue sits between intake and decode, and the result is
//   held in an output register, so intake keeps going while a result
//   waits; when rsp_tready stays low the queue fills and req_tready
//   drops once both entries are taken.
// reset (synchronous, active high) empties the queue and the result
//   register and sets the decoder to expect a new length varint.
`default_nettype none
module varint_length_id_deframer_top #(
   parameter int MAX_VARINT_BYTES = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [7:0] payload_byte, [39:8] packet_id,
                                         // [71:40] payload_length
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic             rsp_tlast
);
   import vld_pkg::*;

   queue_out_type q_out;
   logic          q_pop;

   vld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_out      (q_out),
      .q_pop      (q_pop)
   );

   vld_back #(
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ sv/vld_checker.sv @@
// port-level checks for the deframer, bound to the top level
`default_nettype none
module vld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import vld_pkg::*;

   logic hdr_or_err;
   assign hdr_or_err = (rsp_tuser == ST_HDR) || (rsp_tuser == ST_LEN_LONG) ||
                       (rsp_tuser == ST_ID_LONG) || (rsp_tuser == ST_SHORT);

   // no result can appear right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   // an empty packet always closes the frame with a zero length
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> rsp_tlast && (rsp_tdata[71:40] == 32'd0))
      else $error("empty packet without last or with length");

   a_hdr_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hdr_or_err |-> !rsp_tlast && (rsp_tdata == 72'd0))
      else $error("header or error beat carries data");

   // a byte entering with nothing in flight yields a result after the queue and result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && rsp_tready && (req_tdata == req_tdata)
         ##1 rsp_tready ##0 !rsp_tvalid |=> rsp_tvalid)
      else $error("result missing after two cycles");

endmodule

bind varint_length_id_deframer_top vld_checker u_vld_checker (.*);
`default_nettype wire
